// File: design/y2r_pkg.sv
// ----------------------------------------------------------------------------
// YUYV to RGB converter package
// Shared widths, types and output format codes of the converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

   localparam int BYTE_WIDTH     = 8;
   localparam int PIXEL_WIDTH    = 24;
   localparam int FORMAT_WIDTH   = 3;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   typedef logic [BYTE_WIDTH-1:0]     byte_type;
   typedef logic [PIXEL_WIDTH-1:0]    pixel_type;
   typedef logic [FORMAT_WIDTH-1:0]   format_type;
   typedef logic [CSR_ADDR_WIDTH-1:0] csr_addr_type;
   typedef logic [CSR_DATA_WIDTH-1:0] csr_data_type;

   localparam format_type FMT_RGB565 = 3'd0;
   localparam format_type FMT_RGB888 = 3'd1;
   localparam format_type FMT_RED    = 3'd2;
   localparam format_type FMT_GREEN  = 3'd3;
   localparam format_type FMT_BLUE   = 3'd4;

   localparam logic REG_OUTPUT_FORMAT = 1'b0;

endpackage

// File: design/y2r_req_if.sv
// ----------------------------------------------------------------------------
// YUYV request channel
// Valid/ready channel that carries one YUYV group per transaction.
// ----------------------------------------------------------------------------
interface y2r_req_if
   import y2r_pkg::*;
   ;
   logic     valid;
   logic     ready;
   byte_type luma_first;
   byte_type chroma_blue;
   byte_type luma_second;
   byte_type chroma_red;

   modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                   input ready);
   modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                 output ready);
endinterface

// File: design/y2r_rsp_if.sv
// ----------------------------------------------------------------------------
// RGB response channel
// Valid/ready channel that carries one pixel pair per transaction.
// ----------------------------------------------------------------------------
interface y2r_rsp_if
   import y2r_pkg::*;
   ;
   logic      valid;
   logic      ready;
   pixel_type pixel_first;
   pixel_type pixel_second;

   modport source (output valid, pixel_first, pixel_second, input ready);
   modport sink (input valid, pixel_first, pixel_second, output ready);
endinterface

// File: design/yuyv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// YUYV to RGB converter core
// Converts one YUYV group into two packed RGB pixels through a five-stage
// pipeline, with the output format set over an APB register port.
// ----------------------------------------------------------------------------
// The core accepts one YUYV transaction per clock cycle unless a stalled
// response channel fills the pipeline. The five register stages are the
// chroma offset, the constant multiplies, the channel offsets, the luma sums
// and the saturation with packing. Each stage holds its own valid bit and
// moves on whenever the stage after it is empty or moving, so empty slots
// are filled while the response channel stalls. The output format register
// lies at byte address 0 and should only be written while the core is idle.
module yuyv_to_rgb_converter_core
   import y2r_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   y2r_req_if.sink      req_yuyv,
   y2r_rsp_if.source    rsp_rgb,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  csr_addr_type csr_paddr,
   input  csr_data_type csr_pwdata,
   output csr_data_type csr_prdata,
   output logic         csr_pready
);

   localparam int STAGES = 5;

   format_type format_ff;
   logic       csr_write;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES:0]   advance;

   byte_type           s1_y0_ff, s1_y1_ff;
   logic signed [8:0]  s1_u_ff, s1_v_ff;

   byte_type           s2_y0_ff, s2_y1_ff;
   logic signed [8:0]  s2_u_ff, s2_v_ff;
   logic signed [15:0] s2_pr_ff, s2_pgu_ff, s2_pgv_ff, s2_pb_ff;

   byte_type           s3_y0_ff, s3_y1_ff;
   logic signed [9:0]  s3_rd_ff, s3_gd_ff, s3_bd_ff;
   logic signed [16:0] gsum;

   logic signed [9:0]  s4_r0_ff, s4_g0_ff, s4_b0_ff;
   logic signed [9:0]  s4_r1_ff, s4_g1_ff, s4_b1_ff;

   pixel_type          s5_p0_ff, s5_p1_ff;

   function automatic byte_type clamp_byte(input logic signed [9:0] x);
      byte_type res;
      if (x < 0) begin
         res = '0;
      end else if (x > 10'sd255) begin
         res = '1;
      end else begin
         res = x[7:0];
      end
      return res;
   endfunction

   function automatic pixel_type pack_pixel(input format_type fmt,
                                            input logic signed [9:0] rc,
                                            input logic signed [9:0] gc,
                                            input logic signed [9:0] bc);
      byte_type  r, g, b;
      pixel_type res;
      r = clamp_byte(rc);
      g = clamp_byte(gc);
      b = clamp_byte(bc);
      case (fmt)
         FMT_RGB565: res = {8'd0, r[7:3], g[7:2], b[7:3]};
         FMT_RGB888: res = {r, g, b};
         FMT_RED:    res = {16'd0, r};
         FMT_GREEN:  res = {16'd0, g};
         FMT_BLUE:   res = {16'd0, b};
         default:    res = '0;
      endcase
      return res;
   endfunction

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_OUTPUT_FORMAT) ?
                       {{(CSR_DATA_WIDTH-FORMAT_WIDTH){1'b0}}, format_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_RGB565;
      end else if (csr_write && csr_paddr[2] == REG_OUTPUT_FORMAT) begin
         format_ff <= csr_pwdata[FORMAT_WIDTH-1:0];
      end
   end

   // Flow control.
   always_comb begin
      advance[STAGES] = rsp_rgb.ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
   end

   assign req_yuyv.ready = advance[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (advance[0]) begin
            valid_ff[0] <= req_yuyv.valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (advance[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign gsum = 17'(s2_pgu_ff) + 17'(s2_pgv_ff);

   // Datapath.
   always_ff @(posedge clock) begin
      if (advance[0]) begin
         s1_y0_ff <= req_yuyv.luma_first;
         s1_y1_ff <= req_yuyv.luma_second;
         s1_u_ff  <= $signed({1'b0, req_yuyv.chroma_blue}) - 9'sd128;
         s1_v_ff  <= $signed({1'b0, req_yuyv.chroma_red}) - 9'sd128;
      end
      if (advance[1]) begin
         s2_y0_ff  <= s1_y0_ff;
         s2_y1_ff  <= s1_y1_ff;
         s2_u_ff   <= s1_u_ff;
         s2_v_ff   <= s1_v_ff;
         s2_pr_ff  <= 16'(s1_v_ff) * 16'sd103;
         s2_pgu_ff <= 16'(s1_u_ff) * 16'sd88;
         s2_pgv_ff <= 16'(s1_v_ff) * 16'sd183;
         s2_pb_ff  <= 16'(s1_u_ff) * 16'sd198;
      end
      if (advance[2]) begin
         s3_y0_ff <= s2_y0_ff;
         s3_y1_ff <= s2_y1_ff;
         s3_rd_ff <= 10'(s2_v_ff) + 10'(s2_pr_ff >>> 8);
         s3_gd_ff <= 10'(gsum >>> 8);
         s3_bd_ff <= 10'(s2_u_ff) + 10'(s2_pb_ff >>> 8);
      end
      if (advance[3]) begin
         s4_r0_ff <= $signed({2'b00, s3_y0_ff}) + s3_rd_ff;
         s4_g0_ff <= $signed({2'b00, s3_y0_ff}) - s3_gd_ff;
         s4_b0_ff <= $signed({2'b00, s3_y0_ff}) + s3_bd_ff;
         s4_r1_ff <= $signed({2'b00, s3_y1_ff}) + s3_rd_ff;
         s4_g1_ff <= $signed({2'b00, s3_y1_ff}) - s3_gd_ff;
         s4_b1_ff <= $signed({2'b00, s3_y1_ff}) + s3_bd_ff;
      end
      if (advance[4]) begin
         s5_p0_ff <= pack_pixel(format_ff, s4_r0_ff, s4_g0_ff, s4_b0_ff);
         s5_p1_ff <= pack_pixel(format_ff, s4_r1_ff, s4_g1_ff, s4_b1_ff);
      end
   end

   assign rsp_rgb.valid        = valid_ff[STAGES-1];
   assign rsp_rgb.pixel_first  = s5_p0_ff;
   assign rsp_rgb.pixel_second = s5_p1_ff;

endmodule
